FILE: rtl/core/bpc_pkg.sv
`default_nettype none

package bpc_pkg;

   // field widths of the request and response items
   localparam int FUNC_W      = 3;
   localparam int FILE_W      = 8;
   localparam int BLOCK_W     = 20;
   localparam int SEL_W       = 4;
   localparam int FRAME_OUT_W = 4;

   // defaults for the top level parameters
   localparam int FRAMES_DEF  = 16;
   localparam int REF_MAX_DEF = 255;

   // most response items one flush can produce
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   // request function codes
   localparam logic [FUNC_W-1:0] FN_GET   = 3'd0;
   localparam logic [FUNC_W-1:0] FN_DIRTY = 3'd1;
   localparam logic [FUNC_W-1:0] FN_PIN   = 3'd2;
   localparam logic [FUNC_W-1:0] FN_UNPIN = 3'd3;
   localparam logic [FUNC_W-1:0] FN_FLUSH = 3'd4;
   localparam logic [FUNC_W-1:0] FN_DROP  = 3'd5;

   // response status codes
   localparam logic STATUS_OK         = 1'b0;
   localparam logic STATUS_ALL_PINNED = 1'b1;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACK,
      ST_TAG_RD,
      ST_TAG_CHK,
      ST_SWEEP_RD,
      ST_SWEEP_CHK,
      ST_FILL,
      ST_FL_SCAN,
      ST_FL_CAP,
      ST_FL_END,
      ST_DROP_RD,
      ST_DROP_CHK,
      ST_EMIT
   } state_type;

   // one response item
   typedef struct packed {
      logic [FRAME_OUT_W-1:0] frame_out;
      logic                   hit;
      logic                   load_req;
      logic                   writeback_req;
      logic [FILE_W-1:0]      wb_file;
      logic [BLOCK_W-1:0]     wb_block;
      logic                   status;
      logic                   last;
   } rsp_item_type;

   // write enables toward the frame memory
   typedef struct packed {
      logic tag_we;
      logic refs_we;
   } mem_ctl_type;

   // results of the shared compare unit
   typedef struct packed {
      logic file_eq;
      logic tag_eq;
      logic refs_zero;
   } unit_flags_type;

endpackage

`default_nettype wire

FILE: rtl/core/bpc_req_if.sv
`default_nettype none

interface bpc_req_if;
   logic                          valid;
   logic                          ready;
   logic [bpc_pkg::FUNC_W-1:0]    func;
   logic [bpc_pkg::FILE_W-1:0]    file_id;
   logic [bpc_pkg::BLOCK_W-1:0]   block_num;
   logic [bpc_pkg::SEL_W-1:0]     frame_sel;

   modport source (output valid, func, file_id, block_num, frame_sel, input ready);
   modport sink   (input valid, func, file_id, block_num, frame_sel, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bpc_rsp_if.sv
`default_nettype none

interface bpc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bpc_pkg::FRAME_OUT_W-1:0] frame_out;
   logic                            hit;
   logic                            load_req;
   logic                            writeback_req;
   logic [bpc_pkg::FILE_W-1:0]      wb_file;
   logic [bpc_pkg::BLOCK_W-1:0]     wb_block;
   logic                            status;
   logic                            last;

   modport source (output valid, frame_out, hit, load_req, writeback_req, wb_file, wb_block,
                   status, last, input ready);
   modport sink   (input valid, frame_out, hit, load_req, writeback_req, wb_file, wb_block,
                   status, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bpc_mem.sv
`default_nettype none

module bpc_mem #(
   parameter int FRAMES = bpc_pkg::FRAMES_DEF,
   parameter int IDX_W  = $clog2(FRAMES),
   parameter int REF_W  = $clog2(bpc_pkg::REF_MAX_DEF + 1)
) (
   input  wire logic                         clock,
   input  wire logic [IDX_W-1:0]             rd_addr,
   input  wire logic [IDX_W-1:0]             wr_addr,
   input  wire bpc_pkg::mem_ctl_type         ctl,
   input  wire logic [bpc_pkg::FILE_W-1:0]   wr_file,
   input  wire logic [bpc_pkg::BLOCK_W-1:0]  wr_block,
   input  wire logic [REF_W-1:0]             wr_refs,
   output logic      [bpc_pkg::FILE_W-1:0]   rd_file,
   output logic      [bpc_pkg::BLOCK_W-1:0]  rd_block,
   output logic      [REF_W-1:0]             rd_refs
);
   import bpc_pkg::*;

   logic [FILE_W-1:0]  tag_file_ff  [FRAMES];
   logic [BLOCK_W-1:0] tag_block_ff [FRAMES];
   logic [REF_W-1:0]   refs_ff      [FRAMES];

   logic [FILE_W-1:0]  rd_file_ff;
   logic [BLOCK_W-1:0] rd_block_ff;
   logic [REF_W-1:0]   rd_refs_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ctl.tag_we) begin
         tag_file_ff[wr_addr]  <= wr_file;
         tag_block_ff[wr_addr] <= wr_block;
      end
      if (ctl.refs_we) begin
         refs_ff[wr_addr] <= wr_refs;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_file_ff  <= tag_file_ff[rd_addr];
      rd_block_ff <= tag_block_ff[rd_addr];
      rd_refs_ff  <= refs_ff[rd_addr];
   end

   assign rd_file  = rd_file_ff;
   assign rd_block = rd_block_ff;
   assign rd_refs  = rd_refs_ff;

endmodule

`default_nettype wire

FILE: rtl/core/bpc_unit.sv
`default_nettype none

module bpc_unit #(
   parameter int REF_MAX = bpc_pkg::REF_MAX_DEF,
   parameter int REF_W   = $clog2(REF_MAX + 1)
) (
   input  wire logic [bpc_pkg::FILE_W-1:0]   key_file,
   input  wire logic [bpc_pkg::BLOCK_W-1:0]  key_block,
   input  wire logic [bpc_pkg::FILE_W-1:0]   rd_file,
   input  wire logic [bpc_pkg::BLOCK_W-1:0]  rd_block,
   input  wire logic [REF_W-1:0]             rd_refs,
   output bpc_pkg::unit_flags_type           flags,
   output logic      [REF_W-1:0]             refs_inc,
   output logic      [REF_W-1:0]             refs_dec
);
   import bpc_pkg::*;

   localparam logic [REF_W-1:0] REF_TOP = REF_W'(REF_MAX);

   // tag compare against the frame entry just read
   always_comb begin
      flags.file_eq   = (rd_file == key_file);
      flags.tag_eq    = (rd_file == key_file) && (rd_block == key_block);
      flags.refs_zero = (rd_refs == '0);
   end

   // saturating increment and plain decrement of the reference count
   assign refs_inc = (rd_refs == REF_TOP) ? rd_refs : rd_refs + 1'b1;
   assign refs_dec = rd_refs - 1'b1;

endmodule

`default_nettype wire

FILE: rtl/core/bpc_seq.sv
`default_nettype none

module bpc_seq #(
   parameter int FRAMES  = bpc_pkg::FRAMES_DEF,
   parameter int REF_MAX = bpc_pkg::REF_MAX_DEF,
   parameter int IDX_W   = $clog2(FRAMES),
   parameter int REF_W   = $clog2(REF_MAX + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   bpc_req_if.sink                           req_chan,
   bpc_rsp_if.source                         rsp_chan,
   output logic      [IDX_W-1:0]             rd_addr,
   output logic      [IDX_W-1:0]             wr_addr,
   output bpc_pkg::mem_ctl_type              mem_ctl,
   output logic      [bpc_pkg::FILE_W-1:0]   key_file,
   output logic      [bpc_pkg::BLOCK_W-1:0]  key_block,
   output logic      [REF_W-1:0]             wr_refs,
   input  wire logic [bpc_pkg::FILE_W-1:0]   rd_file,
   input  wire logic [bpc_pkg::BLOCK_W-1:0]  rd_block,
   input  wire bpc_pkg::unit_flags_type      flags,
   input  wire logic [REF_W-1:0]             refs_inc,
   input  wire logic [REF_W-1:0]             refs_dec
);
   import bpc_pkg::*;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAMES - 1);
   localparam logic [REF_W-1:0] REF_INIT = (REF_MAX < 2) ? REF_W'(REF_MAX) : REF_W'(2);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_RESULTS - 1);

   state_type           state_ff,    state_in;
   logic [FUNC_W-1:0]   func_ff,     func_in;
   logic [FILE_W-1:0]   fid_ff,      fid_in;
   logic [BLOCK_W-1:0]  blk_ff,      blk_in;
   logic [SEL_W-1:0]    sel_ff,      sel_in;
   logic [IDX_W-1:0]    idx_ff,      idx_in;
   logic [IDX_W-1:0]    hand_ff,     hand_in;
   logic [IDX_W-1:0]    victim_ff,   victim_in;
   logic [CNT_W-1:0]    cnt_ff,      cnt_in;
   logic                have_ff,     have_in;
   logic                empty_ff,    empty_in;
   logic                unpinned_ff, unpinned_in;
   rsp_item_type        item_ff,     item_in;
   rsp_item_type        out_ff,      out_in;
   logic                out_valid_ff, out_valid_in;
   logic [FRAMES-1:0]   valid_ff,    valid_in;
   logic [FRAMES-1:0]   dirty_ff,    dirty_in;
   logic [FRAMES-1:0]   pinned_ff,   pinned_in;

   logic               out_free;
   logic               idx_last;
   logic [IDX_W-1:0]   hand_next;
   logic [IDX_W-1:0]   sel_idx;
   logic               sel_ok;
   logic               empty_now;
   logic               unpinned_now;
   logic [IDX_W-1:0]   victim_now;

   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign idx_last  = (idx_ff == IDX_LAST);
   assign hand_next = (hand_ff == IDX_LAST) ? '0 : hand_ff + 1'b1;
   assign sel_idx   = IDX_W'(sel_ff);
   assign sel_ok    = (32'(sel_ff) < FRAMES);
   assign key_file  = fid_ff;
   assign key_block = blk_ff;

   // track first empty frame and any unpinned frame during the tag scan
   always_comb begin
      empty_now    = empty_ff;
      victim_now   = victim_ff;
      unpinned_now = unpinned_ff || !pinned_ff[idx_ff];
      if (!empty_ff && !valid_ff[idx_ff]) begin
         empty_now  = 1'b1;
         victim_now = idx_ff;
      end
   end

   // sequencer: next state, memory control and flag updates
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      fid_in       = fid_ff;
      blk_in       = blk_ff;
      sel_in       = sel_ff;
      idx_in       = idx_ff;
      hand_in      = hand_ff;
      victim_in    = victim_ff;
      cnt_in       = cnt_ff;
      have_in      = have_ff;
      empty_in     = empty_ff;
      unpinned_in  = unpinned_ff;
      item_in      = item_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      valid_in     = valid_ff;
      dirty_in     = dirty_ff;
      pinned_in    = pinned_ff;
      rd_addr      = idx_ff;
      wr_addr      = idx_ff;
      mem_ctl      = '0;
      wr_refs      = refs_inc;
      req_chan.ready = 1'b0;

      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               func_in      = req_chan.func;
               fid_in       = req_chan.file_id;
               blk_in       = req_chan.block_num;
               sel_in       = req_chan.frame_sel;
               idx_in       = '0;
               cnt_in       = '0;
               have_in      = 1'b0;
               empty_in     = 1'b0;
               unpinned_in  = 1'b0;
               item_in      = '0;
               item_in.last = 1'b1;
               unique case (req_chan.func)
                  FN_GET:   state_in = ST_TAG_RD;
                  FN_FLUSH: state_in = ST_FL_SCAN;
                  FN_DROP:  state_in = ST_DROP_RD;
                  default:  state_in = ST_ACK;
               endcase
            end
         end

         // mark dirty, pin, unpin and unused codes
         ST_ACK: begin
            if (func_ff inside {FN_DIRTY, FN_PIN, FN_UNPIN}) begin
               item_in.frame_out = sel_ff;
               if (sel_ok && valid_ff[sel_idx]) begin
                  case (func_ff)
                     FN_DIRTY: dirty_in[sel_idx]  = 1'b1;
                     FN_PIN:   pinned_in[sel_idx] = 1'b1;
                     default:  pinned_in[sel_idx] = 1'b0;
                  endcase
               end
            end
            state_in = ST_EMIT;
         end

         ST_TAG_RD: begin
            rd_addr  = idx_ff;
            state_in = ST_TAG_CHK;
         end

         // hit bumps the count, otherwise walk on
         ST_TAG_CHK: begin
            if (valid_ff[idx_ff] && flags.tag_eq) begin
               mem_ctl.refs_we   = 1'b1;
               wr_addr           = idx_ff;
               wr_refs           = refs_inc;
               item_in.frame_out = FRAME_OUT_W'(idx_ff);
               item_in.hit       = 1'b1;
               state_in          = ST_EMIT;
            end else begin
               empty_in    = empty_now;
               victim_in   = victim_now;
               unpinned_in = unpinned_now;
               if (idx_last) begin
                  if (empty_now) begin
                     state_in = ST_FILL;
                  end else if (!unpinned_now) begin
                     item_in.status = STATUS_ALL_PINNED;
                     state_in       = ST_EMIT;
                  end else begin
                     state_in = ST_SWEEP_RD;
                  end
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_TAG_RD;
               end
            end
         end

         ST_SWEEP_RD: begin
            rd_addr  = hand_ff;
            state_in = ST_SWEEP_CHK;
         end

         // clock sweep: skip pinned, take count zero, else decrement
         ST_SWEEP_CHK: begin
            if (pinned_ff[hand_ff]) begin
               hand_in  = hand_next;
               state_in = ST_SWEEP_RD;
            end else if (flags.refs_zero) begin
               victim_in = hand_ff;
               if (dirty_ff[hand_ff]) begin
                  item_in.writeback_req = 1'b1;
                  item_in.wb_file       = rd_file;
                  item_in.wb_block      = rd_block;
               end
               state_in = ST_FILL;
            end else begin
               mem_ctl.refs_we = 1'b1;
               wr_addr         = hand_ff;
               wr_refs         = refs_dec;
               hand_in         = hand_next;
               state_in        = ST_SWEEP_RD;
            end
         end

         // install the new tag in the victim frame
         ST_FILL: begin
            mem_ctl.tag_we     = 1'b1;
            mem_ctl.refs_we    = 1'b1;
            wr_addr            = victim_ff;
            wr_refs            = REF_INIT;
            valid_in[victim_ff]  = 1'b1;
            dirty_in[victim_ff]  = 1'b0;
            pinned_in[victim_ff] = 1'b0;
            item_in.frame_out  = FRAME_OUT_W'(victim_ff);
            item_in.load_req   = 1'b1;
            state_in           = ST_EMIT;
         end

         // flush: a held item goes out once the next dirty frame is seen
         ST_FL_SCAN: begin
            if (valid_ff[idx_ff] && dirty_ff[idx_ff]) begin
               if (have_ff) begin
                  if (out_free) begin
                     out_in       = item_ff;
                     out_in.last  = 1'b0;
                     out_valid_in = 1'b1;
                     have_in      = 1'b0;
                  end
               end else begin
                  rd_addr          = idx_ff;
                  dirty_in[idx_ff] = 1'b0;
                  state_in         = ST_FL_CAP;
               end
            end else if (idx_last) begin
               state_in = ST_FL_END;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_FL_CAP: begin
            item_in               = '0;
            item_in.frame_out     = FRAME_OUT_W'(idx_ff);
            item_in.writeback_req = 1'b1;
            item_in.wb_file       = rd_file;
            item_in.wb_block      = rd_block;
            have_in               = 1'b1;
            cnt_in                = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST || idx_last) begin
               item_in.last = 1'b1;
               state_in     = ST_EMIT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_FL_SCAN;
            end
         end

         ST_FL_END: begin
            if (!have_ff) begin
               item_in = '0;
            end
            item_in.last = 1'b1;
            state_in     = ST_EMIT;
         end

         ST_DROP_RD: begin
            rd_addr  = idx_ff;
            state_in = ST_DROP_CHK;
         end

         // drop every frame whose file id matches
         ST_DROP_CHK: begin
            if (valid_ff[idx_ff] && flags.file_eq) begin
               valid_in[idx_ff]  = 1'b0;
               dirty_in[idx_ff]  = 1'b0;
               pinned_in[idx_ff] = 1'b0;
            end
            if (idx_last) begin
               state_in = ST_EMIT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_DROP_RD;
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               out_in       = item_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hand_ff      <= '0;
         out_valid_ff <= 1'b0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         pinned_ff    <= '0;
         have_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hand_ff      <= hand_in;
         out_valid_ff <= out_valid_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         pinned_ff    <= pinned_in;
         have_ff      <= have_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      fid_ff      <= fid_in;
      blk_ff      <= blk_in;
      sel_ff      <= sel_in;
      idx_ff      <= idx_in;
      victim_ff   <= victim_in;
      cnt_ff      <= cnt_in;
      empty_ff    <= empty_in;
      unpinned_ff <= unpinned_in;
      item_ff     <= item_in;
      out_ff      <= out_in;
   end

   // response channel
   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.frame_out     = out_ff.frame_out;
   assign rsp_chan.hit           = out_ff.hit;
   assign rsp_chan.load_req      = out_ff.load_req;
   assign rsp_chan.writeback_req = out_ff.writeback_req;
   assign rsp_chan.wb_file       = out_ff.wb_file;
   assign rsp_chan.wb_block      = out_ff.wb_block;
   assign rsp_chan.status        = out_ff.status;
   assign rsp_chan.last          = out_ff.last;

   // a filled frame is present and unpinned right after the fill
   a_fill_installs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |=> valid_ff[$past(victim_ff)] && !pinned_ff[$past(victim_ff)])
      else $error("victim frame not installed after fill");

   // an all-pinned error ends its request
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status == STATUS_ALL_PINNED) |-> out_ff.last && !out_ff.load_req)
      else $error("all-pinned error item not final or requests a load");

   // a hit never asks for a load or a writeback
   a_hit_no_io: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.hit) |-> !out_ff.load_req && !out_ff.writeback_req)
      else $error("hit item also requests disk traffic");

   // the sweep only decrements unpinned frames
   a_sweep_unpinned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP_CHK && mem_ctl.refs_we) |-> !pinned_ff[hand_ff])
      else $error("sweep touched a pinned frame");

endmodule

`default_nettype wire

FILE: rtl/core/buffer_pool_clock_replacement_top.sv
// Page-frame directory for a buffer pool with clock replacement.
// req_chan takes one request item (func, file_id, block_num, frame_sel) when
// valid and ready are both high; rsp_chan returns one or more response items,
// the final one with last set. ready is high only while the sequencer is idle.
// A get scans the tags one frame at a time: one memory read, then one compare.
// A hit in frame i ends the scan there; a miss fills the first empty frame,
// reports all-pinned, or else starts the clock sweep.
// The sweep reads and checks each frame it visits and fills the victim.
// Mark dirty, pin, unpin and unused codes need no scan; drop visits every
// frame; flush scans the frames and reads each dirty frame it captures. The
// get, sweep and drop steps all go through the single read port of the frame
// memory and the one shared compare and count unit.
// Responses sit in an output register: a new request is taken while the last
// response still waits, and a stalled receiver holds the sequencer in place
// before its next response, so nothing is dropped.
// Reset empties every frame and clears the dirty, pinned marks and the clock
// hand; tags and counts are written on fill before they are ever read.
`default_nettype none

module buffer_pool_clock_replacement_top #(
   parameter int FRAMES  = bpc_pkg::FRAMES_DEF,
   parameter int REF_MAX = bpc_pkg::REF_MAX_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   bpc_req_if.sink   req_chan,
   bpc_rsp_if.source rsp_chan
);
   import bpc_pkg::*;

   localparam int IDX_W = $clog2(FRAMES);
   localparam int REF_W = $clog2(REF_MAX + 1);

   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   wr_addr;
   mem_ctl_type        mem_ctl;
   logic [FILE_W-1:0]  key_file;
   logic [BLOCK_W-1:0] key_block;
   logic [REF_W-1:0]   wr_refs;
   logic [FILE_W-1:0]  rd_file;
   logic [BLOCK_W-1:0] rd_block;
   logic [REF_W-1:0]   rd_refs;
   unit_flags_type     flags;
   logic [REF_W-1:0]   refs_inc;
   logic [REF_W-1:0]   refs_dec;

   // sequencer with frame flags and output register
   bpc_seq #(
      .FRAMES  (FRAMES),
      .REF_MAX (REF_MAX),
      .IDX_W   (IDX_W),
      .REF_W   (REF_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .mem_ctl   (mem_ctl),
      .key_file  (key_file),
      .key_block (key_block),
      .wr_refs   (wr_refs),
      .rd_file   (rd_file),
      .rd_block  (rd_block),
      .flags     (flags),
      .refs_inc  (refs_inc),
      .refs_dec  (refs_dec)
   );

   // tag and count memory
   bpc_mem #(
      .FRAMES (FRAMES),
      .IDX_W  (IDX_W),
      .REF_W  (REF_W)
   ) u_mem (
      .clock    (clock),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .ctl      (mem_ctl),
      .wr_file  (key_file),
      .wr_block (key_block),
      .wr_refs  (wr_refs),
      .rd_file  (rd_file),
      .rd_block (rd_block),
      .rd_refs  (rd_refs)
   );

   // shared compare and count unit
   bpc_unit #(
      .REF_MAX (REF_MAX),
      .REF_W   (REF_W)
   ) u_unit (
      .key_file  (key_file),
      .key_block (key_block),
      .rd_file   (rd_file),
      .rd_block  (rd_block),
      .rd_refs   (rd_refs),
      .flags     (flags),
      .refs_inc  (refs_inc),
      .refs_dec  (refs_dec)
   );

endmodule

`default_nettype wire
